/* rtl/lz77esc_pkg.sv */
`timescale 1ns / 1ps
package lz77esc_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // largest copy length the hardware ever runs, whatever the register says
   localparam logic [LEN_W-1:0] COPY_CAP = 7'd80;

   localparam logic [BYTE_W-1:0] END_CODE      = 8'h00;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'h40;
   localparam logic [BYTE_W-1:0] BIAS_RESET    = 8'h20;
   localparam logic [LEN_W-1:0]  LONGEST_RESET = 7'd80;

   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_BIAS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGEST_COPY = 2'd2;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_OFFSET = 2'd1;
   localparam logic [1:0] FAULT_LENGTH = 2'd2;

   typedef struct packed {
      logic       push_lit;
      logic       save_offset;
      logic       start_copy;
      logic       emit_fault;
      logic [1:0] fault_code;
      logic       read_issue;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic code_zero;
      logic code_escape;
      logic off_bad;
      logic len_bad;
      logic len_zero;
      logic out_free;
      logic pair_done;
      logic last_byte;
   } status_type;

endpackage

/* rtl/lz77esc_ctrl.sv */
`timescale 1ns / 1ps
module lz77esc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lz77esc_pkg::status_type status,
   output lz77esc_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_OFFSET  = 5'b00010,
      ST_LENGTH  = 5'b00100,
      ST_COPY_RD = 5'b01000,
      ST_COPY_WR = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = ((state_ff == ST_IDLE) || (state_ff == ST_OFFSET) ||
                        (state_ff == ST_LENGTH)) && status.out_free;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.fault_code = lz77esc_pkg::FAULT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !status.code_zero) begin
               if (status.code_escape) begin
                  state_in = ST_OFFSET;
               end else begin
                  cmd.push_lit = 1'b1;
               end
            end
         end
         ST_OFFSET: begin
            if (accept) begin
               if (status.code_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.save_offset = 1'b1;
                  state_in = ST_LENGTH;
               end
            end
         end
         ST_LENGTH: begin
            if (accept) begin
               state_in = ST_IDLE;
               if (!status.code_zero) begin
                  if (status.off_bad) begin
                     cmd.emit_fault = 1'b1;
                     cmd.fault_code = lz77esc_pkg::FAULT_OFFSET;
                  end else if (status.len_bad) begin
                     cmd.emit_fault = 1'b1;
                     cmd.fault_code = lz77esc_pkg::FAULT_LENGTH;
                  end else if (!status.len_zero) begin
                     cmd.start_copy = 1'b1;
                     state_in = ST_COPY_RD;
                  end
               end
            end
         end
         ST_COPY_RD: begin
            cmd.read_issue = 1'b1;
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            // a finished pair waits here until the output register frees up
            if (!status.pair_done || status.out_free) begin
               cmd.commit = 1'b1;
               state_in = status.last_byte ? ST_IDLE : ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/lz77esc_dp.sv */
`timescale 1ns / 1ps
module lz77esc_dp #(
   parameter int HISTORY_DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [lz77esc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lz77esc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [lz77esc_pkg::BYTE_W-1:0]           code_byte,
   input  lz77esc_pkg::cmd_type                     cmd,
   output lz77esc_pkg::status_type                  status,
   input  logic                                     rsp_tready,
   output logic                                     rsp_valid,
   output logic [lz77esc_pkg::BYTE_W-1:0]           rsp_first,
   output logic [lz77esc_pkg::BYTE_W-1:0]           rsp_second,
   output logic                                     rsp_second_valid,
   output logic                                     rsp_last,
   output logic [1:0]                               rsp_fault
);

   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W  = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
   localparam logic [PTR_W:0]    DEPTH_EXT  = (PTR_W + 1)'(HISTORY_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(HISTORY_DEPTH);
   localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(HISTORY_DEPTH);

   localparam int BW = lz77esc_pkg::BYTE_W;
   localparam int LW = lz77esc_pkg::LEN_W;

   // configuration
   logic [BW-1:0] escape_ff;
   logic [BW-1:0] bias_ff;
   logic [LW-1:0] longest_ff;

   // history ring
   logic [BW-1:0]     history_ff [HISTORY_DEPTH];
   logic [PTR_W-1:0]  ptr_ff, ptr_in, ptr_next;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              wr_en;
   logic [BW-1:0]     wr_data;
   logic [PTR_W-1:0]  rd_addr;
   logic [BW-1:0]     rd_data_ff;
   logic              rd_ok_ff;

   // parse and copy state
   logic [BW-1:0]    held_offset_ff;
   logic [PTR_W-1:0] off_ff;
   logic [LW-1:0]    remain_ff;
   logic             half_ff;
   logic [BW-1:0]    first_hold_ff;

   // output register
   logic          out_valid_ff;
   logic [BW-1:0] out_first_ff;
   logic [BW-1:0] out_second_ff;
   logic          out_second_valid_ff;
   logic          out_last_ff;
   logic [1:0]    out_fault_ff;

   logic [BW-1:0]    off_diff;
   logic [CMP_W-1:0] off_wide;
   logic [BW-1:0]    len_diff;
   logic [LW-1:0]    limit;
   logic [BW-1:0]    copy_byte;
   logic             pair_done;
   logic             out_free;
   logic [PTR_W:0]   wrap_sum;

   assign off_diff = held_offset_ff - bias_ff;
   assign off_wide = CMP_W'(off_diff);
   assign len_diff = code_byte - bias_ff;
   assign limit    = (longest_ff > lz77esc_pkg::COPY_CAP) ? lz77esc_pkg::COPY_CAP : longest_ff;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign pair_done = half_ff || (remain_ff == LW'(1));
   assign copy_byte = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      status.code_zero   = (code_byte == lz77esc_pkg::END_CODE);
      status.code_escape = (code_byte == escape_ff);
      status.off_bad     = (held_offset_ff < bias_ff) || (off_wide >= DEPTH_CMP);
      status.len_bad     = (code_byte < bias_ff) || (len_diff > {1'b0, limit});
      status.len_zero    = (code_byte == bias_ff);
      status.out_free    = out_free;
      status.pair_done   = pair_done;
      status.last_byte   = (remain_ff == LW'(1));
   end

   // ring arithmetic: slot of the offset-th newest byte, and the next free slot
   assign wrap_sum = {1'b0, ptr_ff} + DEPTH_EXT - {1'b0, off_ff};
   assign rd_addr  = (ptr_ff >= off_ff) ? (ptr_ff - off_ff) : wrap_sum[PTR_W-1:0];
   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);

   assign wr_en   = cmd.push_lit || cmd.commit;
   assign wr_data = cmd.push_lit ? code_byte : copy_byte;
   assign ptr_in  = wr_en ? ptr_next : ptr_ff;
   assign fill_in = (wr_en && (fill_ff != FILL_FULL)) ? fill_ff + FILL_W'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         history_ff[ptr_next] <= wr_data;
      end
      if (cmd.read_issue) begin
         rd_data_ff <= history_ff[rd_addr];
         // slots never written since reset read as zero
         rd_ok_ff   <= (FILL_W'(off_ff) < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff      <= lz77esc_pkg::ESCAPE_RESET;
         bias_ff        <= lz77esc_pkg::BIAS_RESET;
         longest_ff     <= lz77esc_pkg::LONGEST_RESET;
         ptr_ff         <= '0;
         fill_ff        <= '0;
         held_offset_ff <= '0;
         half_ff        <= 1'b0;
         remain_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               lz77esc_pkg::CSR_ESCAPE_CODE:  escape_ff  <= csr_wdata;
               lz77esc_pkg::CSR_FIELD_BIAS:   bias_ff    <= csr_wdata;
               lz77esc_pkg::CSR_LONGEST_COPY: longest_ff <= csr_wdata[LW-1:0];
               default: ;
            endcase
         end
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         if (cmd.save_offset) begin
            held_offset_ff <= code_byte;
         end
         if (cmd.start_copy) begin
            remain_ff <= len_diff[LW-1:0];
            half_ff   <= 1'b0;
         end else if (cmd.commit) begin
            remain_ff <= remain_ff - LW'(1);
            half_ff   <= !pair_done;
         end
         if (cmd.push_lit || cmd.emit_fault || (cmd.commit && pair_done)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_copy) begin
         off_ff <= off_wide[PTR_W-1:0];
      end
      if (cmd.commit && !pair_done) begin
         first_hold_ff <= copy_byte;
      end
      if (cmd.push_lit) begin
         out_first_ff        <= code_byte;
         out_second_ff       <= '0;
         out_second_valid_ff <= 1'b0;
         out_last_ff         <= 1'b1;
         out_fault_ff        <= lz77esc_pkg::FAULT_NONE;
      end else if (cmd.emit_fault) begin
         out_first_ff        <= '0;
         out_second_ff       <= '0;
         out_second_valid_ff <= 1'b0;
         out_last_ff         <= 1'b1;
         out_fault_ff        <= cmd.fault_code;
      end else if (cmd.commit && pair_done) begin
         if (half_ff) begin
            out_first_ff        <= first_hold_ff;
            out_second_ff       <= copy_byte;
            out_second_valid_ff <= 1'b1;
         end else begin
            out_first_ff        <= copy_byte;
            out_second_ff       <= '0;
            out_second_valid_ff <= 1'b0;
         end
         out_last_ff  <= (remain_ff == LW'(1));
         out_fault_ff <= lz77esc_pkg::FAULT_NONE;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_first        = out_first_ff;
   assign rsp_second       = out_second_ff;
   assign rsp_second_valid = out_second_valid_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_fault        = out_fault_ff;

endmodule

/* rtl/lz77_escape_decompressor.sv */
`timescale 1ns / 1ps
// channel   direction  signals                       payload
// req       in         req_tvalid/tready/tdata[7:0]  code_byte
// rsp       out        rsp_tvalid/tready/tdata[15:0] first_byte, second_byte
//                      rsp_tuser[2:0], rsp_tlast     second_valid, fault; run_last
// csr       in         csr_we/index[1:0]/wdata[7:0]  escape_code, field_bias, longest_copy
//
// literal, escape, offset and length bytes take one cycle each while the output
// register is free; a copy of n bytes does one history read and one
// history write per byte through the single memory port, results every two bytes.
// reset is synchronous; a fill count makes unwritten history read as zero, so no
// clearing pass is needed. a stalled result holds the copy sequencer in place.
module lz77_escape_decompressor #(
   parameter int HISTORY_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] code_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] first_byte, [15:8] second_byte
   output logic [2:0]  rsp_tuser,    // [0] second_valid, [2:1] fault
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   lz77esc_pkg::cmd_type    cmd;
   lz77esc_pkg::status_type status;

   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic       second_valid;
   logic [1:0] fault;

   lz77esc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lz77esc_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .code_byte        (req_tdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_first        (first_byte),
      .rsp_second       (second_byte),
      .rsp_second_valid (second_valid),
      .rsp_last         (rsp_tlast),
      .rsp_fault        (fault)
   );

   assign rsp_tdata = {second_byte, first_byte};
   assign rsp_tuser = {fault, second_valid};

endmodule

/* tb/lz77_escape_decompressor_tb.sv */
`timescale 1ns / 1ps
module lz77_escape_decompressor_tb;

   localparam int HIST_DEPTH   = 128;
   localparam int SETTLE_TICKS = 24;
   localparam int PHASE_CODES  = 46;

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'b001,
      PHASE_OFFSET = 3'b010,
      PHASE_LENGTH = 3'b100
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       second_valid;
      logic       run_last;
      logic [1:0] fault;
   } out_word_type;

   class decompress_checker;
      logic [7:0]      escape_code;
      logic [7:0]      field_bias;
      logic [6:0]      longest_copy;
      logic [7:0]      hist [HIST_DEPTH];
      logic [6:0]      newest;
      parse_phase_type phase;
      logic [7:0]      held_offset;
      out_word_type    awaited_words [$];
      int              errors;

      function new();
         escape_code  = lz77esc_pkg::ESCAPE_RESET;
         field_bias   = lz77esc_pkg::BIAS_RESET;
         longest_copy = lz77esc_pkg::LONGEST_RESET;
         foreach (hist[i]) hist[i] = 8'h00;
         newest      = '0;
         phase       = PHASE_IDLE;
         held_offset = 8'h00;
         errors      = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [7:0] value);
         case (index)
            lz77esc_pkg::CSR_ESCAPE_CODE:  escape_code  = value;
            lz77esc_pkg::CSR_FIELD_BIAS:   field_bias   = value;
            lz77esc_pkg::CSR_LONGEST_COPY: longest_copy = value[6:0];
            default: ;
         endcase
      endfunction

      function void push_byte(logic [7:0] b);
         newest = newest + 7'd1;
         hist[newest] = b;
      endfunction

      function void add_word(logic [7:0] a, logic [7:0] b, logic bv, logic last,
                             logic [1:0] flt);
         out_word_type w;
         w.first_byte   = a;
         w.second_byte  = b;
         w.second_valid = bv;
         w.run_last     = last;
         w.fault        = flt;
         awaited_words.push_back(w);
      endfunction

      function void note_code(logic [7:0] c);
         int unsigned limit;
         int unsigned off;
         int unsigned len;
         logic [7:0]  a;
         logic [7:0]  b;
         logic        bv;
         if (c == lz77esc_pkg::END_CODE) begin
            phase = PHASE_IDLE;
            return;
         end
         case (phase)
            PHASE_OFFSET: begin
               held_offset = c;
               phase = PHASE_LENGTH;
            end
            PHASE_LENGTH: begin
               phase = PHASE_IDLE;
               limit = (longest_copy > lz77esc_pkg::COPY_CAP) ? lz77esc_pkg::COPY_CAP
                                                              : longest_copy;
               if (held_offset < field_bias || held_offset - field_bias >= HIST_DEPTH) begin
                  add_word(8'h00, 8'h00, 1'b0, 1'b1, lz77esc_pkg::FAULT_OFFSET);
               end else if (c < field_bias || c - field_bias > limit) begin
                  add_word(8'h00, 8'h00, 1'b0, 1'b1, lz77esc_pkg::FAULT_LENGTH);
               end else begin
                  off = held_offset - field_bias;
                  len = c - field_bias;
                  // each byte lands in the history before the next read, so overlaps repeat
                  for (int unsigned i = 0; i < len; i += 2) begin
                     a = hist[7'(newest - 7'(off))];
                     push_byte(a);
                     b  = 8'h00;
                     bv = 1'b0;
                     if (i + 1 < len) begin
                        b  = hist[7'(newest - 7'(off))];
                        bv = 1'b1;
                        push_byte(b);
                     end
                     add_word(a, b, bv, i + 2 >= len, lz77esc_pkg::FAULT_NONE);
                  end
               end
            end
            default: begin
               if (c == escape_code) begin
                  phase = PHASE_OFFSET;
               end else begin
                  push_byte(c);
                  add_word(c, 8'h00, 1'b0, 1'b1, lz77esc_pkg::FAULT_NONE);
               end
            end
         endcase
      endfunction

      function void check_word(logic [15:0] data, logic [2:0] user, logic last);
         out_word_type got;
         out_word_type want;
         got.first_byte   = data[7:0];
         got.second_byte  = data[15:8];
         got.second_valid = user[0];
         got.fault        = user[2:1];
         got.run_last     = last;
         if (awaited_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t unexpected result: first %h second %h sv %b last %b fault %0d",
                        $realtime, got.first_byte, got.second_byte, got.second_valid,
                        got.run_last, got.fault);
            return;
         end
         want = awaited_words.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"%0t result mismatch: expected first %h second %h sv %b last %b",
                         " fault %0d, got first %h second %h sv %b last %b fault %0d"},
                        $realtime, want.first_byte, want.second_byte, want.second_valid,
                        want.run_last, want.fault, got.first_byte, got.second_byte,
                        got.second_valid, got.run_last, got.fault);
         end
      endfunction

      function int pending();
         return awaited_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = lz77esc_pkg::CSR_ESCAPE_CODE;
   logic [7:0]  csr_wdata = 8'h00;

   decompress_checker sb = new();
   int codes_sent = 0;
   int sender_idle_pct = 34;
   int receiver_idle_pct = 61;

   lz77_escape_decompressor #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   task automatic send_code(input logic [7:0] c);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_code(c);
      codes_sent++;
      if (codes_sent < 100) begin
         sender_idle_pct   = 34;
         receiver_idle_pct = 61;
      end else if (codes_sent < 200) begin
         sender_idle_pct   = 61;
         receiver_idle_pct = 34;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
   endtask

   // hold the stream until every result is out, then let a trailing pair settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] esc, input logic [7:0] bias,
                             input logic [7:0] longest);
      csr_we    <= 1'b1;
      csr_index <= lz77esc_pkg::CSR_ESCAPE_CODE;
      csr_wdata <= esc;
      @(posedge clock);
      sb.write_reg(lz77esc_pkg::CSR_ESCAPE_CODE, esc);
      csr_index <= lz77esc_pkg::CSR_FIELD_BIAS;
      csr_wdata <= bias;
      @(posedge clock);
      sb.write_reg(lz77esc_pkg::CSR_FIELD_BIAS, bias);
      csr_index <= lz77esc_pkg::CSR_LONGEST_COPY;
      csr_wdata <= longest;
      @(posedge clock);
      sb.write_reg(lz77esc_pkg::CSR_LONGEST_COPY, longest);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] not_end(int unsigned v);
      return (v == 0) ? 8'd1 : 8'(v);
   endfunction

   task automatic emit_token();
      logic [7:0]  esc;
      logic [7:0]  bias;
      logic [7:0]  b;
      int unsigned lim;
      int unsigned max_off;
      int unsigned max_len;
      int unsigned off;
      int unsigned len;
      int          r;
      esc  = sb.escape_code;
      bias = sb.field_bias;
      lim  = (sb.longest_copy > lz77esc_pkg::COPY_CAP) ? lz77esc_pkg::COPY_CAP
                                                       : sb.longest_copy;
      max_off = 255 - bias;
      if (max_off > HIST_DEPTH - 1) max_off = HIST_DEPTH - 1;
      max_len = 255 - bias;
      if (max_len > lim) max_len = lim;
      off = $urandom_range(0, max_off);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_len)
                                        : $urandom_range(0, (max_len < 8) ? max_len : 8);
      r = $urandom_range(0, 99);
      if (esc == lz77esc_pkg::END_CODE || r < 40) begin
         do b = 8'($urandom_range(1, 255)); while (b == esc);
         send_code(b);
      end else if (r < 78) begin
         send_code(esc);
         send_code(not_end(bias + off));
         send_code(not_end(bias + len));
      end else if (r < 86) begin
         if (bias > 1 && (bias + HIST_DEPTH > 255 || $urandom_range(0, 1)))
            b = 8'($urandom_range(1, bias - 1));
         else
            b = 8'($urandom_range(bias + HIST_DEPTH, 255));
         send_code(esc);
         send_code(b);
         send_code(8'($urandom_range(1, 255)));
      end else if (r < 94) begin
         if (bias > 1 && (bias + lim >= 255 || $urandom_range(0, 1)))
            b = 8'($urandom_range(1, bias - 1));
         else
            b = 8'($urandom_range(bias + lim + 1, 255));
         send_code(esc);
         send_code(not_end(bias + off));
         send_code(b);
      end else begin
         // broken pairs and stray bytes
         case ($urandom_range(0, 4))
            0: send_code(lz77esc_pkg::END_CODE);
            1: begin
               send_code(esc);
               send_code(lz77esc_pkg::END_CODE);
            end
            2: begin
               send_code(esc);
               send_code(not_end(bias + off));
               send_code(lz77esc_pkg::END_CODE);
            end
            3: begin
               send_code(esc);
               send_code(esc);
               send_code(not_end(bias + len));
            end
            default: send_code(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic run_random(input int n);
      int start;
      start = codes_sent;
      while (codes_sent - start < n) emit_token();
   endtask

   logic [7:0] opening_codes [27] = '{
      8'hFF, 8'h01, 8'h80,
      8'd64, 8'd132, 8'd35,  // copy out of never-written history
      8'd64, 8'd32,  8'd37,  // offset 0, odd length: repeats the newest byte
      8'd64, 8'd33,  8'd112, // longest copy
      8'd64, 8'd34,  8'd32,  // zero length
      8'd64, 8'd10,  8'd10,  // offset and length both bad
      8'd64, 8'd160, 8'd40,  // offset past the history
      8'd64, 8'd40,  8'd113, // length over the limit
      8'd64, 8'd0,           // end code inside a pair
      8'd0
   };

   logic [7:0] escape_set  [5] = '{8'd255, 8'd1,   8'd0,   8'd200, 8'd64};
   logic [7:0] bias_set    [5] = '{8'd0,   8'd255, 8'd100, 8'd128, 8'd32};
   logic [7:0] longest_set [5] = '{8'd80,  8'd1,   8'd40,  8'd127, 8'd80};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening_codes[i]) send_code(opening_codes[i]);
      wait_drained();
      run_random(PHASE_CODES);
      wait_drained();
      foreach (escape_set[i]) begin
         write_regs(escape_set[i], bias_set[i], longest_set[i]);
         run_random(PHASE_CODES);
         wait_drained();
      end
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lz77esc_pkg.sv
rtl/lz77esc_ctrl.sv
rtl/lz77esc_dp.sv
rtl/lz77_escape_decompressor.sv
tb/lz77_escape_decompressor_tb.sv
